[rtl/epoch_to_calendar_unit_defines.svh]
// assertion macros used by the back part of the epoch to calendar rtl
`ifndef EPOCH_TO_CALENDAR_UNIT_DEFINES_SVH
`define EPOCH_TO_CALENDAR_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define E2C_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define E2C_ASSERT_NR(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define E2C_ASSERT(label, clk, rst_n, prop, msg)
`define E2C_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

[rtl/e2c_pkg.sv]
// shared types and constants for the epoch to calendar unit
`timescale 1ns / 1ps
package e2c_pkg;
    localparam int unsigned QueueDepth = 2;

    // split of one timestamp into time of day and day count
    typedef struct packed {
        logic [5:0]  sec;
        logic [5:0]  min;
        logic [4:0]  hour;
        logic [2:0]  wday;
        logic [16:0] days;
    } e2c_split_t;

    // length of a month by index 0..11
    function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
        logic [4:0] r;
        case (m)
            4'd1:                     r = leap ? 5'd29 : 5'd28;
            4'd3, 4'd5, 4'd8, 4'd10:  r = 5'd30;
            default:                  r = 5'd31;
        endcase
        return r;
    endfunction

    // gregorian rule on a year offset from 1970, exact up to 2199 (2100 is the only century year handled)
    function automatic logic is_leap(input logic [7:0] off);
        logic [11:0] y;
        logic l;
        y = 12'd1970 + {4'd0, off};
        if (y[1:0] != 2'd0)
            l = 1'b0;
        else if (y == 12'd2100)
            l = 1'b0;
        else
            l = 1'b1;
        return l;
    endfunction
endpackage

[rtl/e2c_front.sv]
// front part: input register, division by constants and weekday
`timescale 1ns / 1ps
module e2c_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  logic [31:0]         epoch_seconds,
    output logic                q_valid,
    input  logic                q_ready,
    output e2c_pkg::e2c_split_t q_data
);
    import e2c_pkg::*;

    typedef enum logic [2:0] {F_IDLE, F_SEC, F_MIN, F_HOUR, F_WDAY, F_OUT} fstate_t;

    fstate_t     state_reg;
    logic [31:0] t_reg;
    logic [26:0] q60_reg;
    e2c_split_t  res_reg;
    logic [26:0] div60;
    logic [20:0] div60b;
    logic [16:0] div24;
    logic [17:0] dp4;
    logic [14:0] div7;
    logic [31:0] prod;

    // reciprocal multiplies, each followed by a register
    assign div60  = 27'((64'(t_reg) * 64'd2290649225) >> 37);
    assign div60b = 21'((64'(q60_reg) * 64'd2290649225) >> 37);
    assign div24  = 17'((64'(q60_reg) * 64'd2863311531) >> 36);
    assign dp4    = {1'b0, res_reg.days} + 18'd4;
    assign div7   = 15'((40'(dp4) * 40'd149797) >> 20);
    assign prod   = 32'({div60, 6'd0} - {4'd0, div60, 2'd0});

    assign full    = (state_reg != F_IDLE);
    assign q_valid = (state_reg == F_OUT);
    assign q_data  = res_reg;

    // sequencer over the divisions
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
        end
        else
        begin
            case (state_reg)
                F_IDLE:
                begin
                    if (push)
                    begin
                        t_reg     <= epoch_seconds;
                        state_reg <= F_SEC;
                    end
                end
                F_SEC:
                begin
                    res_reg.sec <= 6'(t_reg - prod);
                    q60_reg     <= div60;
                    state_reg   <= F_MIN;
                end
                F_MIN:
                begin
                    res_reg.min <= 6'(q60_reg - 27'(div60b * 27'd60));
                    q60_reg     <= {6'd0, div60b};
                    state_reg   <= F_HOUR;
                end
                F_HOUR:
                begin
                    res_reg.hour <= 5'(q60_reg - 27'(div24 * 27'd24));
                    res_reg.days <= div24;
                    state_reg    <= F_WDAY;
                end
                F_WDAY:
                begin
                    res_reg.wday <= 3'(dp4 - 18'(div7 * 18'd7)) + 3'd1;
                    state_reg    <= F_OUT;
                end
                F_OUT:
                begin
                    if (q_ready)
                        state_reg <= F_IDLE;
                end
                default: state_reg <= F_IDLE;
            endcase
        end
    end
endmodule

[rtl/e2c_queue.sv]
// short queue between the front and back parts
`timescale 1ns / 1ps
module e2c_queue #(
    parameter int unsigned DEPTH = e2c_pkg::QueueDepth
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  e2c_pkg::e2c_split_t in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output e2c_pkg::e2c_split_t out_data
);
    import e2c_pkg::*;
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    e2c_split_t      mem_reg [DEPTH];
    logic [AW-1:0]   wp_reg, rp_reg;
    logic [AW:0]     cnt_reg;
    logic            wr, rd;

    assign in_ready  = (cnt_reg != (AW+1)'(DEPTH));
    assign out_valid = (cnt_reg != '0);
    assign out_data  = mem_reg[rp_reg];
    assign wr = in_valid && in_ready;
    assign rd = out_valid && out_ready;

    // storage
    always_ff @(posedge clk)
    begin
        if (wr)
            mem_reg[wp_reg] <= in_data;
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (wr)
                wp_reg <= (wp_reg == AW'(DEPTH - 1)) ? '0 : wp_reg + 1'b1;
            if (rd)
                rp_reg <= (rp_reg == AW'(DEPTH - 1)) ? '0 : rp_reg + 1'b1;
            cnt_reg <= cnt_reg + (AW+1)'(wr) - (AW+1)'(rd);
        end
    end
endmodule

[rtl/e2c_back.sv]
// back part: year and month walks and the result register
`timescale 1ns / 1ps
`include "epoch_to_calendar_unit_defines.svh"
module e2c_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_valid,
    output logic                q_ready,
    input  e2c_pkg::e2c_split_t q_data,
    output logic                empty,
    input  logic                pop,
    output logic [5:0]          second_of_minute,
    output logic [5:0]          minute_of_hour,
    output logic [4:0]          hour_of_day,
    output logic [2:0]          weekday,
    output logic [4:0]          day_of_month,
    output logic [3:0]          month_number,
    output logic [7:0]          year_offset
);
    import e2c_pkg::*;

    typedef enum logic [1:0] {B_IDLE, B_YEAR, B_MONTH, B_DONE} bstate_t;

    bstate_t     state_reg;
    logic [16:0] days_reg;
    logic [7:0]  year_reg;
    logic [3:0]  month_reg;
    logic [8:0]  ylen;
    logic [4:0]  mlen;
    logic        leap;

    assign leap = is_leap(year_reg);
    assign ylen = leap ? 9'd366 : 9'd365;
    assign mlen = month_len(month_reg, leap);

    assign q_ready          = (state_reg == B_IDLE);
    assign empty            = (state_reg != B_DONE);
    assign day_of_month     = 5'(days_reg) + 5'd1;
    assign month_number     = month_reg + 4'd1;
    assign year_offset      = year_reg;

    // walk sequencer with held time fields
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
        end
        else
        begin
            case (state_reg)
                B_IDLE:
                begin
                    if (q_valid)
                    begin
                        days_reg         <= q_data.days;
                        year_reg         <= '0;
                        month_reg        <= '0;
                        second_of_minute <= q_data.sec;
                        minute_of_hour   <= q_data.min;
                        hour_of_day      <= q_data.hour;
                        weekday          <= q_data.wday;
                        state_reg        <= B_YEAR;
                    end
                end
                B_YEAR:
                begin
                    if (days_reg < {8'd0, ylen})
                        state_reg <= B_MONTH;
                    else
                    begin
                        days_reg <= days_reg - {8'd0, ylen};
                        year_reg <= year_reg + 8'd1;
                    end
                end
                B_MONTH:
                begin
                    if (month_reg == 4'd11 || days_reg < {12'd0, mlen})
                        state_reg <= B_DONE;
                    else
                    begin
                        days_reg  <= days_reg - {12'd0, mlen};
                        month_reg <= month_reg + 4'd1;
                    end
                end
                B_DONE:
                begin
                    if (pop)
                        state_reg <= B_IDLE;
                end
                default: state_reg <= B_IDLE;
            endcase
        end
    end

    `E2C_ASSERT(a_month_range, clk, rst_n, (state_reg == B_DONE) |-> (month_reg <= 4'd11), "month out of range")
    `E2C_ASSERT(a_year_range, clk, rst_n, (state_reg == B_DONE) |-> (year_reg <= 8'd136), "year out of range")
    `E2C_ASSERT(a_days_month, clk, rst_n, (state_reg == B_DONE) |-> (days_reg < 17'd31), "day out of range")
    `E2C_ASSERT(a_hold, clk, rst_n, (state_reg == B_DONE && !pop) |=> (state_reg == B_DONE && $stable(year_reg)), "result lost")
endmodule

[rtl/epoch_to_calendar_unit.sv]
// top level of the epoch to calendar unit
`timescale 1ns / 1ps
// Converts unsigned seconds since 1970-01-01 into calendar fields. The front
// part steps through its sec, min, hour and weekday states for the constant
// divisions; the back part walks years one per cycle (up to 136) and months
// one per cycle (up to 12). A two-entry queue lets the front take the next
// item while the back is still walking.
module epoch_to_calendar_unit #(
    parameter int unsigned QUEUE_DEPTH = e2c_pkg::QueueDepth
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [31:0] epoch_seconds,
    output logic        empty,
    input  logic        pop,
    output logic [5:0]  second_of_minute,
    output logic [5:0]  minute_of_hour,
    output logic [4:0]  hour_of_day,
    output logic [2:0]  weekday,
    output logic [4:0]  day_of_month,
    output logic [3:0]  month_number,
    output logic [7:0]  year_offset
);
    import e2c_pkg::*;

    logic       f_valid, f_ready, b_valid, b_ready;
    e2c_split_t f_data, b_data;

    // front part
    e2c_front u_front (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full),
        .epoch_seconds(epoch_seconds),
        .q_valid(f_valid), .q_ready(f_ready), .q_data(f_data)
    );

    // queue
    e2c_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .clk(clk), .rst_n(rst_n),
        .in_valid(f_valid), .in_ready(f_ready), .in_data(f_data),
        .out_valid(b_valid), .out_ready(b_ready), .out_data(b_data)
    );

    // back part
    e2c_back u_back (
        .clk(clk), .rst_n(rst_n),
        .q_valid(b_valid), .q_ready(b_ready), .q_data(b_data),
        .empty(empty), .pop(pop),
        .second_of_minute(second_of_minute), .minute_of_hour(minute_of_hour),
        .hour_of_day(hour_of_day), .weekday(weekday), .day_of_month(day_of_month),
        .month_number(month_number), .year_offset(year_offset)
    );
endmodule

[sim/epoch_to_calendar_checker.sv]
// checker that predicts and compares calendar results of the epoch to calendar unit
`timescale 1ns / 1ps
module epoch_to_calendar_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  logic        full,
    input  logic [31:0] epoch_seconds,
    input  logic        empty,
    input  logic        pop,
    input  logic [5:0]  second_of_minute,
    input  logic [5:0]  minute_of_hour,
    input  logic [4:0]  hour_of_day,
    input  logic [2:0]  weekday,
    input  logic [4:0]  day_of_month,
    input  logic [3:0]  month_number,
    input  logic [7:0]  year_offset,
    output int          fail_count,
    output int          pending_dates,
    output int          dates_checked
);
    typedef struct packed {
        logic [5:0] sec;
        logic [5:0] min;
        logic [4:0] hour;
        logic [2:0] wday;
        logic [4:0] mday;
        logic [3:0] mon;
        logic [7:0] year;
    } cal_date_t;

    cal_date_t expected_dates[$];

    // gregorian leap test on an absolute year
    function automatic bit greg_leap(input int unsigned y);
        return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
    endfunction

    // turn a timestamp into its calendar date
    function automatic cal_date_t seconds_to_date(input logic [31:0] stamp);
        cal_date_t d;
        int unsigned t;
        int unsigned days;
        int unsigned yr;
        int unsigned mo;
        int unsigned mlen;
        int unsigned ylen;
        t = stamp;
        d.sec = 6'(t % 60);
        t = t / 60;
        d.min = 6'(t % 60);
        t = t / 60;
        d.hour = 5'(t % 24);
        days = t / 24;
        d.wday = 3'(((days + 4) % 7) + 1);
        yr = 0;
        ylen = greg_leap(1970) ? 366 : 365;
        while (days >= ylen)
        begin
            days -= ylen;
            yr++;
            ylen = greg_leap(1970 + yr) ? 366 : 365;
        end
        for (mo = 0; mo < 11; mo++)
        begin
            case (mo)
                1: mlen = greg_leap(1970 + yr) ? 29 : 28;
                3, 5, 8, 10: mlen = 30;
                default: mlen = 31;
            endcase
            if (days < mlen)
                break;
            days -= mlen;
        end
        d.mday = 5'(days + 1);
        d.mon = 4'(mo + 1);
        d.year = 8'(yr);
        return d;
    endfunction

    task automatic report(input string what, input int unsigned got, input int unsigned want);
        $display("%0t mismatch on %s: got %0d expected %0d", $time, what, got, want);
        fail_count++;
    endtask

    initial
    begin
        fail_count = 0;
        dates_checked = 0;
    end

    assign pending_dates = expected_dates.size();

    // watch both transfers at each edge
    always @(posedge clk)
    begin
        cal_date_t e;
        if (rst_n)
        begin
            if (push && !full)
                expected_dates.push_back(seconds_to_date(epoch_seconds));
            if (pop && !empty)
            begin
                if (expected_dates.size() == 0)
                begin
                    $display("%0t result transfer with nothing expected", $time);
                    fail_count++;
                end
                else
                begin
                    e = expected_dates.pop_front();
                    dates_checked++;
                    if (second_of_minute != e.sec) report("second", second_of_minute, e.sec);
                    if (minute_of_hour != e.min) report("minute", minute_of_hour, e.min);
                    if (hour_of_day != e.hour) report("hour", hour_of_day, e.hour);
                    if (weekday != e.wday) report("weekday", weekday, e.wday);
                    if (day_of_month != e.mday) report("day", day_of_month, e.mday);
                    if (month_number != e.mon) report("month", month_number, e.mon);
                    if (year_offset != e.year) report("year", year_offset, e.year);
                end
            end
        end
    end
endmodule

[sim/epoch_to_calendar_unit_tb.sv]
// testbench top for the epoch to calendar unit: stimulus, reset and verdict
`timescale 1ns / 1ps
module epoch_to_calendar_unit_tb;
    localparam int NumRandom = 1400;
    localparam int CalmTail = 150;

    logic        clk;
    logic        rst_n;
    logic        push;
    logic        full;
    logic [31:0] epoch_seconds;
    logic        empty;
    logic        pop;
    logic [5:0]  second_of_minute;
    logic [5:0]  minute_of_hour;
    logic [4:0]  hour_of_day;
    logic [2:0]  weekday;
    logic [4:0]  day_of_month;
    logic [3:0]  month_number;
    logic [7:0]  year_offset;
    int          fail_count;
    int          pending_dates;
    int          dates_checked;
    bit          calm;
    bit          hold_off;
    int          stamps_sent;

    epoch_to_calendar_unit dut (.*);

    epoch_to_calendar_checker checker_i (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // overall time limit
    initial
    begin
        #20ms;
        $display("timeout");
        $display("Regression FAIL");
        $finish;
    end

    // offer one timestamp and wait for its transfer
    task automatic send_stamp(input logic [31:0] stamp);
        int gap;
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            push <= 1'b0;
            for (gap = $urandom_range(1, 10); gap > 0; gap--)
                @(posedge clk);
        end
        push <= 1'b1;
        epoch_seconds <= stamp;
        @(posedge clk);
        while (full)
            @(posedge clk);
        stamps_sent++;
    endtask

    // random timestamp, weighted toward boundaries of days, years and the top
    function automatic logic [31:0] pick_stamp();
        logic [31:0] s;
        case ($urandom_range(0, 5))
            0: s = 32'hFFFF_FFFF - $urandom_range(0, 400 * 86400);
            1: s = 32'd4107542400 + $urandom_range(0, 800 * 86400) - 400 * 86400;
            2: s = ($urandom_range(0, 49710) * 86400) + $urandom_range(0, 2) - 1;
            3: s = $urandom_range(0, 3 * 366 * 86400);
            default: s = $urandom();
        endcase
        return s;
    endfunction

    // result side: random pop bursts, one long hold-off
    initial
    begin
        int gap;
        pop <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_off)
            begin
                pop <= 1'b0;
                for (gap = 0; gap < 600; gap++)
                    @(posedge clk);
                hold_off = 1'b0;
            end
            if (!calm && $urandom_range(0, 3) == 0)
            begin
                pop <= 1'b0;
                for (gap = $urandom_range(1, 10); gap > 1; gap--)
                    @(posedge clk);
            end
            else
                pop <= 1'b1;
        end
    end

    initial
    begin
        logic [31:0] directed[$];
        int i;
        int wait_cycles;
        rst_n = 1'b0;
        push = 1'b0;
        epoch_seconds = '0;
        calm = 1'b0;
        hold_off = 1'b0;
        stamps_sent = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes, bit patterns, leap and century edges
        directed = '{32'd0, 32'd59, 32'd60, 32'd3599, 32'd86399, 32'd86400,
                     32'hFFFF_FFFF, 32'hAAAA_AAAA, 32'h5555_5555, 32'h8000_0000,
                     32'h7FFF_FFFF, 32'd68169599, 32'd68256000, 32'd951782400,
                     32'd951868799, 32'd951868800, 32'd4107542399, 32'd4107542400,
                     32'd4112380800, 32'd4112467199, 32'd4112467200, 32'd946684799,
                     32'd978307199, 32'd4294944000};
        foreach (directed[k])
            send_stamp(directed[k]);

        // random part with a long receiver hold-off after the first 300 stamps
        for (i = 0; i < NumRandom; i++)
        begin
            if (i == 300)
                hold_off = 1'b1;
            if (i == NumRandom - CalmTail)
                calm = 1'b1;
            send_stamp(pick_stamp());
        end
        push <= 1'b0;

        wait_cycles = 0;
        while (pending_dates != 0 && wait_cycles < 200000)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (200) @(posedge clk);

        $display("converted %0d timestamps, %0d dates checked, including 2100 and 2106 limits",
                 stamps_sent, dates_checked);
        if (fail_count == 0 && pending_dates == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule

[sim.f]
+incdir+rtl
rtl/e2c_pkg.sv
rtl/e2c_front.sv
rtl/e2c_queue.sv
rtl/e2c_back.sv
rtl/epoch_to_calendar_unit.sv
sim/epoch_to_calendar_checker.sv
sim/epoch_to_calendar_unit_tb.sv
